// ----- src/etp_pkg.sv -----
// Package for the term stream parser: parse phases, event and error codes,
// tag byte values and the result record type. No dependencies.
package etp_pkg;

   localparam int ETP_STACK_DEPTH = 8;

   localparam logic [7:0] VERSION_BYTE = 8'd131;
   localparam logic [7:0] T_SMALL_INT  = 8'd97;
   localparam logic [7:0] T_INTEGER    = 8'd98;
   localparam logic [7:0] T_TUPLE      = 8'd104;
   localparam logic [7:0] T_NIL        = 8'd106;
   localparam logic [7:0] T_LIST       = 8'd108;
   localparam logic [7:0] T_BINARY     = 8'd109;
   localparam logic [7:0] PAIR_ARITY   = 8'd2;

   localparam logic [2:0] EV_SMALL  = 3'd0;
   localparam logic [2:0] EV_INT    = 3'd1;
   localparam logic [2:0] EV_BYTE   = 3'd2;
   localparam logic [2:0] EV_EMPTY  = 3'd3;
   localparam logic [2:0] EV_COMMIT = 3'd4;
   localparam logic [2:0] EV_ERROR  = 3'd5;

   localparam logic [2:0] ERR_PROTO   = 3'd0;
   localparam logic [2:0] ERR_STACK   = 3'd1;
   localparam logic [2:0] ERR_BUF     = 3'd2;
   localparam logic [2:0] ERR_PAIR    = 3'd3;
   localparam logic [2:0] ERR_TAGTYPE = 3'd4;
   localparam logic [2:0] ERR_BINDING = 3'd5;

   typedef enum logic [3:0] {
      PH_LEN,
      PH_VER,
      PH_VALUE,
      PH_LISTCOUNT,
      PH_SMALL,
      PH_INT,
      PH_BINLEN,
      PH_BINDATA,
      PH_BIND,
      PH_ARITY,
      PH_TAGTYPE,
      PH_TAGSMALL,
      PH_TAGINT,
      PH_ERROR
   } phase_type;

   typedef struct packed {
      logic [2:0]  error_code;
      logic [2:0]  depth;
      logic [31:0] tag;
      logic [31:0] value;
      logic        last_byte;
      logic [2:0]  event_kind;
   } result_type;

endpackage

// ----- src/etp_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Read returns the old contents when the same address is written. No dependencies.
module etp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- src/etf_term_stream_parser.sv -----
// Top level of the byte-serial term stream parser with its output skid stage.
// Depends on etp_pkg and on etp_ram for the tag stack.
//
//   channel  direction  payload                                   handshake
//   req      in         tdata[7:0] data byte                      tvalid/tready
//   rsp      out        tdata value,tag,depth,error; tuser kind   tvalid/tready
//   csr      in         wr_data max binary length                 wr_en only
//
// One byte is taken per clock while input is not stopped; each byte is a single
// state update and its event is registered in a result register. The tag stack
// RAM is read ahead at the next depth, so its registered read adds no delay.
// Reset is synchronous and clears the control state and the tag valid bits;
// there is no clearing pass. A second result register absorbs one request while
// the output is stalled, so input stops only when both registers are full.
module etf_term_stream_parser #(
   parameter int STACK_DEPTH = etp_pkg::ETP_STACK_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] value, [63:32] tag, [66:64] depth,
                                    // [69:67] error_code, [71:70] zero
   output logic [2:0]  rsp_tuser,   // [2:0] event_kind
   output logic        rsp_tlast
);

   import etp_pkg::*;

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   phase_type   phase_ff, phase_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] rem_ff, rem_in;
   logic [AW-1:0] depth_ff, depth_in;
   logic [31:0] max_len_ff;

   logic [STACK_DEPTH-1:0] tvalid_ff;
   logic        tzero_ff, tval_ff, byp_ff;
   logic [31:0] byp_data_ff;
   logic [31:0] ram_rd;
   logic [AW-1:0] rd_addr, wr_addr;
   logic        tag_we;
   logic [31:0] tag_wdata;
   logic [31:0] cur_tag;

   logic        req_fire;
   logic [7:0]  b;
   logic [31:0] word_next;
   logic        word_done;
   logic [1:0]  cnt_step;
   logic [AW:0] depth_up;
   logic [AW-1:0] depth_dec;

   logic        emit;
   logic [2:0]  ev_kind, ev_code;
   logic [31:0] ev_value;
   logic        ev_last;
   result_type  ev;

   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   result_type  out_ff, out_in, skid_ff, skid_in;

   assign req_tready = !skid_valid_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign b          = req_tdata;
   assign word_next  = {word_ff[23:0], b};
   assign word_done  = (cnt_ff == 2'd3);
   assign cnt_step   = word_done ? 2'd0 : cnt_ff + 2'd1;
   assign depth_up   = {1'b0, depth_ff} + 1'b1;
   assign depth_dec  = (depth_ff != '0) ? depth_ff - 1'b1 : '0;
   assign wr_addr    = depth_ff - 1'b1;
   assign rd_addr    = depth_in - 1'b1;

   always_comb begin
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      word_in   = word_ff;
      rem_in    = rem_ff;
      depth_in  = depth_ff;
      tag_we    = 1'b0;
      tag_wdata = word_next;
      emit      = 1'b0;
      ev_kind   = EV_SMALL;
      ev_code   = ERR_PROTO;
      ev_value  = '0;
      ev_last   = 1'b0;
      if (req_fire) begin
         unique case (phase_ff)
            PH_LEN: begin
               word_in = word_next;
               cnt_in  = cnt_step;
               if (word_done) begin
                  phase_in = PH_VER;
               end
            end
            PH_VER: begin
               if (b != VERSION_BYTE) begin
                  emit = 1'b1; ev_kind = EV_ERROR; ev_code = ERR_PROTO; phase_in = PH_ERROR;
               end else begin
                  phase_in = PH_VALUE;
               end
            end
            PH_VALUE: begin
               cnt_in = 2'd0;
               priority if (b == T_LIST) begin
                  phase_in = PH_LISTCOUNT;
               end else if (b == T_SMALL_INT) begin
                  phase_in = PH_SMALL;
               end else if (b == T_INTEGER) begin
                  phase_in = PH_INT;
               end else if (b == T_BINARY) begin
                  phase_in = PH_BINLEN;
               end else begin
                  emit = 1'b1; ev_kind = EV_ERROR; ev_code = ERR_PROTO; phase_in = PH_ERROR;
               end
            end
            PH_LISTCOUNT: begin
               word_in = word_next;
               cnt_in  = cnt_step;
               if (word_done) begin
                  if (depth_up >= (AW+1)'(STACK_DEPTH)) begin
                     emit = 1'b1; ev_kind = EV_ERROR; ev_code = ERR_STACK; phase_in = PH_ERROR;
                  end else begin
                     depth_in = depth_up[AW-1:0];
                     phase_in = PH_BIND;
                  end
               end
            end
            PH_SMALL: begin
               emit     = 1'b1;
               ev_kind  = EV_SMALL;
               ev_value = {24'd0, b};
               cnt_in   = 2'd0;
               phase_in = (depth_ff != '0) ? PH_BIND : PH_LEN;
            end
            PH_INT: begin
               word_in = word_next;
               cnt_in  = cnt_step;
               if (word_done) begin
                  emit     = 1'b1;
                  ev_kind  = EV_INT;
                  ev_value = word_next;
                  phase_in = (depth_ff != '0) ? PH_BIND : PH_LEN;
               end
            end
            PH_BINLEN: begin
               word_in = word_next;
               cnt_in  = cnt_step;
               if (word_done) begin
                  priority if (word_next > max_len_ff) begin
                     emit = 1'b1; ev_kind = EV_ERROR; ev_code = ERR_BUF; phase_in = PH_ERROR;
                  end else if (word_next == '0) begin
                     emit     = 1'b1;
                     ev_kind  = EV_EMPTY;
                     phase_in = (depth_ff != '0) ? PH_BIND : PH_LEN;
                  end else begin
                     rem_in   = word_next;
                     phase_in = PH_BINDATA;
                  end
               end
            end
            PH_BINDATA: begin
               emit     = 1'b1;
               ev_kind  = EV_BYTE;
               ev_value = {24'd0, b};
               ev_last  = (rem_ff <= 32'd1);
               if (ev_last) begin
                  rem_in   = '0;
                  cnt_in   = 2'd0;
                  phase_in = (depth_ff != '0) ? PH_BIND : PH_LEN;
               end else begin
                  rem_in = rem_ff - 32'd1;
               end
            end
            PH_BIND: begin
               priority if (b == T_NIL) begin
                  emit     = 1'b1;
                  ev_kind  = EV_COMMIT;
                  depth_in = depth_dec;
                  cnt_in   = 2'd0;
                  phase_in = (depth_dec != '0) ? PH_BIND : PH_LEN;
               end else if (b == T_TUPLE) begin
                  phase_in = PH_ARITY;
               end else begin
                  emit = 1'b1; ev_kind = EV_ERROR; ev_code = ERR_BINDING; phase_in = PH_ERROR;
               end
            end
            PH_ARITY: begin
               if (b != PAIR_ARITY) begin
                  emit = 1'b1; ev_kind = EV_ERROR; ev_code = ERR_PAIR; phase_in = PH_ERROR;
               end else begin
                  phase_in = PH_TAGTYPE;
               end
            end
            PH_TAGTYPE: begin
               cnt_in = 2'd0;
               priority if (b == T_SMALL_INT) begin
                  phase_in = PH_TAGSMALL;
               end else if (b == T_INTEGER) begin
                  phase_in = PH_TAGINT;
               end else begin
                  emit = 1'b1; ev_kind = EV_ERROR; ev_code = ERR_TAGTYPE; phase_in = PH_ERROR;
               end
            end
            PH_TAGSMALL: begin
               tag_we    = (depth_ff != '0);
               tag_wdata = {24'd0, b};
               phase_in  = PH_VALUE;
            end
            PH_TAGINT: begin
               word_in = word_next;
               cnt_in  = cnt_step;
               if (word_done) begin
                  tag_we   = (depth_ff != '0);
                  phase_in = PH_VALUE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // The tag of the innermost binding is read ahead at the depth that follows
   // this cycle; a write made in the same cycle is forwarded through a bypass register.
   etp_ram #(
      .WIDTH (32),
      .DEPTH (STACK_DEPTH),
      .AW    (AW)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (wr_addr),
      .wr_data (tag_wdata),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   assign cur_tag = tzero_ff ? 32'd0 :
                    byp_ff   ? byp_data_ff :
                    tval_ff  ? ram_rd : 32'd0;

   assign ev.event_kind = ev_kind;
   assign ev.value      = ev_value;
   assign ev.tag        = cur_tag;
   assign ev.depth      = 3'(depth_ff);
   assign ev.last_byte  = ev_last;
   assign ev.error_code = (ev_kind == EV_ERROR) ? ev_code : ERR_PROTO;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (out_valid_ff && rsp_tready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else if (emit) begin
            out_in = ev;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (emit) begin
         if (!out_valid_ff) begin
            out_in       = ev;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = ev;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEN;
         cnt_ff        <= 2'd0;
         word_ff       <= '0;
         rem_ff        <= '0;
         depth_ff      <= '0;
         max_len_ff    <= 32'hFFFF_FFFF;
         tvalid_ff     <= '0;
         tzero_ff      <= 1'b1;
         tval_ff       <= 1'b0;
         byp_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         cnt_ff        <= cnt_in;
         word_ff       <= word_in;
         rem_ff        <= rem_in;
         depth_ff      <= depth_in;
         tzero_ff      <= (depth_in == '0);
         tval_ff       <= (depth_in != '0) && tvalid_ff[rd_addr];
         byp_ff        <= tag_we;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         if (tag_we) begin
            tvalid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= tag_wdata;
      out_ff      <= out_in;
      skid_ff     <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_ff.error_code, out_ff.depth, out_ff.tag, out_ff.value};
   assign rsp_tuser  = out_ff.event_kind;
   assign rsp_tlast  = out_ff.last_byte;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a result while the output register is empty");

   a_error_sticks: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ERROR) |=> (phase_ff == PH_ERROR))
      else $error("parser left the error phase without reset");

   a_error_event_enters_error: assert property (@(posedge clock) disable iff (reset)
      (emit && ev_kind == EV_ERROR) |=> (phase_ff == PH_ERROR))
      else $error("error event issued without entering the error phase");

   a_no_event_after_error: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_ERROR) |-> !emit)
      else $error("request produced an event after an error");

endmodule

// ----- sim/etf_term_stream_parser_tb.sv -----
// Testbench for etf_term_stream_parser: feeds encoded terms byte by byte, predicts
// every event in a model of the parser and compares it with each accepted result.
// Depends on etp_pkg and on the parser RTL; reads no files.
module etf_term_stream_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import etp_pkg::*;

   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 4;
   localparam int MAX_DEPTH    = ETP_STACK_DEPTH - 1;
   localparam logic [2:0] NO_ERROR = 3'd0;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [31:0] csr_wr_data = '0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [71:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   phase_type   parse_ph   = PH_LEN;
   int          word_bytes = 0;
   logic [31:0] shift_word = '0;
   logic [31:0] bin_left   = '0;
   int          depth_now  = 0;
   logic [31:0] tag_mem [ETP_STACK_DEPTH] = '{default: '0};
   bit          halted     = 1'b0;
   logic [31:0] len_limit  = 32'hFFFF_FFFF;

   result_type  expected_events [$];
   logic [7:0]  term_bytes [$];
   int          fail_count  = 0;
   int          bytes_sent  = 0;
   int          idle_cycles = 0;
   int          sink_hold   = 0;
   bit          src_burst   = 1'b0;
   bit          sink_burst  = 1'b0;

   etf_term_stream_parser DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always #10 clock = ~clock;

   function automatic bit shift_in(input logic [7:0] b);
      shift_word = {shift_word[23:0], b};
      if (word_bytes >= 3) begin
         word_bytes = 0;
         return 1'b1;
      end
      word_bytes++;
      return 1'b0;
   endfunction

   function automatic result_type make_event(input logic [2:0] kind, input logic [31:0] val,
                                             input logic is_last, input logic [2:0] code);
      result_type r;
      r.event_kind = kind;
      r.value      = val;
      r.tag        = (depth_now == 0) ? 32'd0 : tag_mem[depth_now - 1];
      r.depth      = depth_now[2:0];
      r.last_byte  = is_last;
      r.error_code = code;
      return r;
   endfunction

   function automatic void value_done();
      word_bytes = 0;
      parse_ph = (depth_now != 0) ? PH_BIND : PH_LEN;
   endfunction

   function automatic void set_tag(input logic [31:0] t);
      if (depth_now != 0) tag_mem[depth_now - 1] = t;
   endfunction

   function automatic bit predict_byte(input logic [7:0] b, output result_type ev);
      bit         fired = 1'b0;
      bit         bad   = 1'b0;
      logic [2:0] code  = ERR_PROTO;
      ev = '0;
      if (halted) return 1'b0;
      case (parse_ph)
         PH_LEN: begin
            if (shift_in(b)) parse_ph = PH_VER;
         end
         PH_VER: begin
            if (b != VERSION_BYTE) bad = 1'b1;
            else parse_ph = PH_VALUE;
         end
         PH_VALUE: begin
            word_bytes = 0;
            case (b)
               T_LIST:      parse_ph = PH_LISTCOUNT;
               T_SMALL_INT: parse_ph = PH_SMALL;
               T_INTEGER:   parse_ph = PH_INT;
               T_BINARY:    parse_ph = PH_BINLEN;
               default:     bad = 1'b1;
            endcase
         end
         PH_LISTCOUNT: begin
            if (shift_in(b)) begin
               if (depth_now + 1 >= ETP_STACK_DEPTH) begin
                  bad  = 1'b1;
                  code = ERR_STACK;
               end else begin
                  depth_now++;
                  value_done();
               end
            end
         end
         PH_SMALL: begin
            ev    = make_event(EV_SMALL, {24'd0, b}, 1'b0, NO_ERROR);
            fired = 1'b1;
            value_done();
         end
         PH_INT: begin
            if (shift_in(b)) begin
               ev    = make_event(EV_INT, shift_word, 1'b0, NO_ERROR);
               fired = 1'b1;
               value_done();
            end
         end
         PH_BINLEN: begin
            if (shift_in(b)) begin
               if (shift_word > len_limit) begin
                  bad  = 1'b1;
                  code = ERR_BUF;
               end else if (shift_word == 0) begin
                  ev    = make_event(EV_EMPTY, 32'd0, 1'b0, NO_ERROR);
                  fired = 1'b1;
                  value_done();
               end else begin
                  bin_left = shift_word;
                  parse_ph = PH_BINDATA;
               end
            end
         end
         PH_BINDATA: begin
            ev    = make_event(EV_BYTE, {24'd0, b}, bin_left <= 1, NO_ERROR);
            fired = 1'b1;
            if (bin_left <= 1) begin
               bin_left = '0;
               value_done();
            end else begin
               bin_left--;
            end
         end
         PH_BIND: begin
            if (b == T_NIL) begin
               ev    = make_event(EV_COMMIT, 32'd0, 1'b0, NO_ERROR);
               fired = 1'b1;
               if (depth_now != 0) depth_now--;
               value_done();
            end else if (b == T_TUPLE) begin
               parse_ph = PH_ARITY;
            end else begin
               bad  = 1'b1;
               code = ERR_BINDING;
            end
         end
         PH_ARITY: begin
            if (b != PAIR_ARITY) begin
               bad  = 1'b1;
               code = ERR_PAIR;
            end else begin
               parse_ph = PH_TAGTYPE;
            end
         end
         PH_TAGTYPE: begin
            word_bytes = 0;
            if (b == T_SMALL_INT) parse_ph = PH_TAGSMALL;
            else if (b == T_INTEGER) parse_ph = PH_TAGINT;
            else begin
               bad  = 1'b1;
               code = ERR_TAGTYPE;
            end
         end
         PH_TAGSMALL: begin
            set_tag({24'd0, b});
            parse_ph = PH_VALUE;
         end
         PH_TAGINT: begin
            if (shift_in(b)) begin
               set_tag(shift_word);
               parse_ph = PH_VALUE;
            end
         end
         default: ;
      endcase
      if (bad) begin
         ev       = make_event(EV_ERROR, 32'd0, 1'b0, code);
         fired    = 1'b1;
         halted   = 1'b1;
         parse_ph = PH_ERROR;
      end
      return fired;
   endfunction

   function automatic void push_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--) term_bytes.push_back(w[8*i +: 8]);
   endfunction

   function automatic void push_header();
      push_word($urandom());
      term_bytes.push_back(VERSION_BYTE);
   endfunction

   function automatic void push_small(input logic [7:0] v);
      term_bytes.push_back(T_SMALL_INT);
      term_bytes.push_back(v);
   endfunction

   function automatic void push_int(input logic [31:0] w);
      term_bytes.push_back(T_INTEGER);
      push_word(w);
   endfunction

   function automatic void push_binary(input logic [31:0] len);
      term_bytes.push_back(T_BINARY);
      push_word(len);
      for (int i = 0; i < len; i++) term_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   function automatic void push_list_open();
      term_bytes.push_back(T_LIST);
      push_word($urandom());
   endfunction

   function automatic void push_binding(input logic [31:0] t, input bit wide);
      term_bytes.push_back(T_TUPLE);
      term_bytes.push_back(PAIR_ARITY);
      if (wide) push_int(t);
      else push_small(t[7:0]);
   endfunction

   function automatic logic [31:0] pick_bin_len();
      logic [31:0] n;
      case ($urandom_range(0, 15))
         0:       n = 32'd0;
         15:      n = $urandom_range(7, 40);
         default: n = $urandom_range(1, 6);
      endcase
      if (n > len_limit) n = len_limit;
      return n;
   endfunction

   function automatic void push_random_value(inout int d, input int max_d, input int list_pct);
      if (d < max_d && $urandom_range(0, 99) < list_pct) begin
         push_list_open();
         d++;
      end else begin
         case ($urandom_range(0, 2))
            0:       push_small(8'($urandom_range(0, 255)));
            1:       push_int($urandom());
            default: push_binary(pick_bin_len());
         endcase
      end
   endfunction

   function automatic void push_random_term(input int max_d);
      int d = 0;
      push_header();
      push_random_value(d, max_d, 50);
      while (d > 0) begin
         if ($urandom_range(0, 4) < 2) begin
            term_bytes.push_back(T_NIL);
            d--;
         end else begin
            push_binding($urandom(), 1'($urandom_range(0, 1)));
            push_random_value(d, max_d, 20);
         end
      end
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int         gap;
      result_type ev;
      gap = src_burst ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      if (predict_byte(b, ev)) expected_events.push_back(ev);
   endtask

   task automatic send_terms();
      while (term_bytes.size() != 0) send_byte(term_bytes.pop_front());
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [31:0] v);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      len_limit = v;
   endtask

   task automatic test_leaf_extremes();
      src_burst = 1'b0;
      push_header();
      push_list_open();
      push_binding(32'd0, 1'b0);
      push_small(8'd0);
      push_binding(32'd255, 1'b0);
      push_small(8'd255);
      push_binding(32'h8000_0000, 1'b1);
      push_int(32'h8000_0000);
      push_binding(32'hFFFF_FFFF, 1'b1);
      push_int(32'h7FFF_FFFF);
      push_binding(32'h7FFF_FFFF, 1'b1);
      push_binary(32'd0);
      push_binding(32'd1, 1'b0);
      push_binary(32'd2);
      term_bytes.push_back(T_NIL);
      push_header();
      push_binary(32'd1);
      send_terms();
   endtask

   task automatic test_deep_nesting();
      src_burst = 1'b1;
      push_header();
      push_list_open();
      for (int lvl = 1; lvl < MAX_DEPTH; lvl++) begin
         push_binding($urandom(), lvl[0]);
         push_list_open();
      end
      push_binding($urandom(), 1'b1);
      push_int($urandom());
      repeat (MAX_DEPTH) term_bytes.push_back(T_NIL);
      // Lists with no bindings report the tag left behind at their depth.
      push_header();
      push_list_open();
      push_binding(32'd9, 1'b0);
      push_list_open();
      term_bytes.push_back(T_NIL);
      term_bytes.push_back(T_NIL);
      push_header();
      push_list_open();
      term_bytes.push_back(T_NIL);
      send_terms();
   endtask

   task automatic test_length_limits();
      src_burst = 1'b0;
      write_limit(32'd0);
      push_header();
      push_binary(32'd0);
      push_header();
      push_list_open();
      push_binding($urandom(), 1'b0);
      push_binary(32'd0);
      term_bytes.push_back(T_NIL);
      send_terms();
      write_limit(32'd5);
      push_header();
      push_binary(32'd5);
      send_terms();
      write_limit(32'hFFFF_FFFF);
      push_header();
      push_binary(32'd12);
      send_terms();
   endtask

   task automatic test_random_terms();
      int start;
      start = bytes_sent;
      while (bytes_sent - start < 250) begin
         if ($urandom_range(0, 24) == 0) begin
            case ($urandom_range(0, 3))
               0:       write_limit(32'd0);
               1:       write_limit(32'hFFFF_FFFF);
               2:       write_limit($urandom_range(1, 8));
               default: write_limit($urandom());
            endcase
         end
         src_burst = ($urandom_range(0, 3) == 0);
         push_random_term($urandom_range(0, MAX_DEPTH));
         send_terms();
      end
   endtask

   task automatic test_backpressure();
      write_limit(32'hFFFF_FFFF);
      src_burst = 1'b1;
      sink_hold = 400;
      push_header();
      push_list_open();
      push_binding($urandom(), 1'b0);
      push_binary(32'd60);
      term_bytes.push_back(T_NIL);
      send_terms();
      drain();
   endtask

   task automatic test_sticky_error();
      logic [2:0] err;
      logic [7:0] bad;
      err = 3'($urandom_range(ERR_PROTO, ERR_BINDING));
      if (err == ERR_BUF) write_limit($urandom_range(0, 8));
      src_burst = 1'b0;
      push_word($urandom());
      case (err)
         ERR_PROTO: begin
            bad = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 1)) begin
               if (bad == VERSION_BYTE) bad = T_NIL;
            end else begin
               term_bytes.push_back(VERSION_BYTE);
               if (bad == T_SMALL_INT || bad == T_INTEGER || bad == T_LIST || bad == T_BINARY)
                  bad = T_NIL;
            end
            term_bytes.push_back(bad);
         end
         ERR_STACK: begin
            term_bytes.push_back(VERSION_BYTE);
            push_list_open();
            repeat (MAX_DEPTH) begin
               push_binding($urandom(), 1'($urandom_range(0, 1)));
               push_list_open();
            end
         end
         ERR_BUF: begin
            term_bytes.push_back(VERSION_BYTE);
            term_bytes.push_back(T_BINARY);
            push_word(len_limit + 1 + $urandom_range(0, 1000));
         end
         ERR_PAIR: begin
            term_bytes.push_back(VERSION_BYTE);
            push_list_open();
            term_bytes.push_back(T_TUPLE);
            bad = 8'($urandom_range(0, 255));
            if (bad == PAIR_ARITY) bad = T_TUPLE;
            term_bytes.push_back(bad);
         end
         ERR_TAGTYPE: begin
            term_bytes.push_back(VERSION_BYTE);
            push_list_open();
            term_bytes.push_back(T_TUPLE);
            term_bytes.push_back(PAIR_ARITY);
            bad = 8'($urandom_range(0, 255));
            if (bad == T_SMALL_INT || bad == T_INTEGER) bad = T_BINARY;
            term_bytes.push_back(bad);
         end
         default: begin
            term_bytes.push_back(VERSION_BYTE);
            push_list_open();
            bad = 8'($urandom_range(0, 255));
            if (bad == T_TUPLE || bad == T_NIL) bad = T_LIST;
            term_bytes.push_back(bad);
         end
      endcase
      // Everything after the error must be swallowed without any event.
      repeat (20) term_bytes.push_back(8'($urandom_range(0, 255)));
      send_terms();
   endtask

   initial begin : result_sink
      int stall;
      forever begin
         if (sink_hold > 0) begin
            stall     = sink_hold;
            sink_hold = 0;
         end else begin
            if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, 18);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : result_check
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            $display("%0t: unexpected event, expected none, actual kind %0h data %0h",
                     $time, rsp_tuser, rsp_tdata);
            fail_count++;
         end else begin
            want = expected_events.pop_front();
            check_field("event_kind", 32'(want.event_kind), 32'(rsp_tuser));
            check_field("value", want.value, rsp_tdata[31:0]);
            check_field("tag", want.tag, rsp_tdata[63:32]);
            check_field("depth", 32'(want.depth), 32'(rsp_tdata[66:64]));
            check_field("last_byte", 32'(want.last_byte), 32'(rsp_tlast));
            check_field("error_code", 32'(want.error_code), 32'(rsp_tdata[69:67]));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_leaf_extremes();
      test_deep_nesting();
      test_length_limits();
      test_random_terms();
      test_backpressure();
      test_sticky_error();
      drain();
      if (fail_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

// ----- filelist.f -----
src/etp_pkg.sv
src/etp_ram.sv
src/etf_term_stream_parser.sv
sim/etf_term_stream_parser_tb.sv
